// ===== hw/rtl/dsn_pkg.sv =====
// ----------------------------------------------------------------------------
// dsn_pkg
// Shared types, codes and the sigmoid lookup for the dense network core.
// ----------------------------------------------------------------------------
package dsn_pkg;

    localparam int VAL_W   = 16;
    localparam int ACT_W   = 13;
    localparam int ACC_W   = 40;
    localparam int PROD_W  = 32;
    localparam int FRAC    = 12;
    localparam int IDX_W   = 6;
    localparam int TAB_N   = 256;
    localparam int CFG_W   = 6;
    localparam int CFG_A_W = 3;

    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_BIAS   = 2'd1;
    localparam logic [1:0] OP_INPUT  = 2'd2;

    localparam logic [CFG_A_W-1:0] REG_LAYERS = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_WIN    = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_W1     = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_W2     = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_W3     = 3'd4;

    localparam logic [63:0] EXP_STEP = 64'd4034748380;

    typedef logic [TAB_N-1:0][ACT_W-1:0] sig_tab_t;

    typedef struct packed {
        logic                    vld;
        logic                    lst;
        logic [IDX_W-1:0]        k;
        logic signed [VAL_W-1:0] act;
    } tok_t;

    typedef struct packed {
        logic w_en;
        logic b_en;
    } cell_wr_t;

    typedef struct packed {
        logic ld;
        logic sh;
    } sh_ctl_t;

    // restoring long division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic sig_tab_t build_sig_tab();
        sig_tab_t    t;
        logic [63:0] p;
        logic [63:0] den;
        logic [63:0] q;
        t = '0;
        p = 64'd1 << 32;
        for (int k = 0; k <= 128; k++)
        begin
            den = (64'd1 << 32) + p;
            if (k < 128)
            begin
                q = udiv64((64'd1 << 44) + (den >> 1), den);
                t[128 + k] = q[ACT_W-1:0];
            end
            if (k > 0)
            begin
                q = udiv64((p << 12) + (den >> 1), den);
                t[128 - k] = q[ACT_W-1:0];
            end
            p = (p * EXP_STEP) >> 32;
        end
        return t;
    endfunction

    localparam sig_tab_t SIG_TAB = build_sig_tab();

    localparam logic signed [ACC_W-1:0] ACC_LIM = 40'sd134217728;

    function automatic logic [ACT_W-1:0] activate(input logic signed [ACC_W-1:0] acc);
        logic [7:0] idx;
        idx = {~acc[27], acc[26:20]};
        if (acc < -ACC_LIM)
            return '0;
        else if (acc >= ACC_LIM)
            return ACT_W'(1 << FRAC);
        else
            return SIG_TAB[idx];
    endfunction

endpackage

// ===== hw/rtl/dsn_cell.sv =====
// ----------------------------------------------------------------------------
// dsn_cell
// One neuron cell: weight column, bias, multiply-accumulate and result shift.
// ----------------------------------------------------------------------------
module dsn_cell
    import dsn_pkg::*;
#(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_LAYERS = 4
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cell_wr_t                           wr,
    input  logic [((MAX_LAYERS-1)*MAX_WIDTH > 1 ? $clog2((MAX_LAYERS-1)*MAX_WIDTH) : 1)-1:0]
                                               w_addr,
    input  logic [(MAX_LAYERS-1 > 1 ? $clog2(MAX_LAYERS-1) : 1)-1:0] b_addr,
    input  logic [(MAX_LAYERS-1 > 1 ? $clog2(MAX_LAYERS-1) : 1)-1:0] lay,
    input  logic signed [VAL_W-1:0]            wr_data,
    input  tok_t                               tok_in,
    output tok_t                               tok_out,
    input  sh_ctl_t                            ctl,
    input  logic [ACT_W-1:0]                   sh_in,
    output logic [ACT_W-1:0]                   sh_out,
    output logic                               done
);

    localparam int WDEPTH = (MAX_LAYERS - 1) * MAX_WIDTH;
    localparam int WAW    = WDEPTH > 1 ? $clog2(WDEPTH) : 1;
    localparam int BDEPTH = MAX_LAYERS - 1;

    logic signed [VAL_W-1:0]  wmem [WDEPTH];
    logic signed [VAL_W-1:0]  bmem [BDEPTH];

    logic [WAW-1:0]           raddr;
    tok_t                     tok_reg;
    logic signed [VAL_W-1:0]  w_q;
    logic signed [VAL_W-1:0]  bias_q;
    logic signed [VAL_W-1:0]  a_reg;
    logic                     va_reg;
    logic                     fa_reg;
    logic                     la_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     vb_reg;
    logic                     fb_reg;
    logic                     lb_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_base;
    logic                     dc_reg;
    logic [ACT_W-1:0]         res_reg;
    logic                     done_reg;
    logic [ACT_W-1:0]         sh_reg;

    assign raddr = WAW'(lay) * WAW'(MAX_WIDTH) + WAW'(tok_in.k);

    always_ff @(posedge clk)
    begin
        if (wr.w_en)
            wmem[w_addr] <= wr_data;
        w_q <= wmem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.b_en)
            bmem[b_addr] <= wr_data;
        bias_q <= bmem[lay];
    end

    always_comb
    begin
        acc_base = fb_reg ? {{(ACC_W-VAL_W-FRAC){bias_q[VAL_W-1]}}, bias_q, {FRAC{1'b0}}}
                          : acc_reg;
        acc_next = acc_base + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg     <= '0;
            va_reg      <= 1'b0;
            vb_reg      <= 1'b0;
            dc_reg      <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            tok_reg     <= tok_in;
            va_reg      <= tok_in.vld;
            vb_reg      <= va_reg;
            dc_reg      <= vb_reg & lb_reg;
            done_reg    <= dc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= tok_in.act;
        fa_reg      <= (tok_in.k == '0);
        la_reg      <= tok_in.lst;
        prod_reg    <= PROD_W'(w_q) * PROD_W'(a_reg);
        fb_reg      <= fa_reg;
        lb_reg      <= la_reg;
        if (vb_reg)
            acc_reg <= acc_next;
        if (dc_reg)
            res_reg <= activate(acc_reg);
        if (ctl.ld)
            sh_reg <= res_reg;
        else if (ctl.sh)
            sh_reg <= sh_in;
    end

    assign tok_out = tok_reg;
    assign sh_out  = sh_reg;
    assign done    = done_reg;

endmodule

// ===== hw/rtl/dense_sigmoid_network_inference_core.sv =====
// ----------------------------------------------------------------------------
// dense_sigmoid_network_inference_core
// Fully connected sigmoid network forward pass on a row of neuron cells.
// ----------------------------------------------------------------------------
//  channel   direction  signals
//  in        input      in_valid/in_ready, opcode, layer_sel, row_idx, col_idx,
//                       value, is_last
//  out       output     out_valid/out_ready, out_index, out_value, out_last
//  cfg       input      cfg_wr_en, cfg_index, cfg_data
//
//  load items and non-final input elements are taken back to back while idle
//  a pass runs, per layer, the n_in feed steps, the trip through the cell
//  row and the n_out drain steps; intake is held for the whole pass
//  reset clears control state only; stores hold garbage until written
//  a stalled output holds the drain, an output register parts the two sides
// ----------------------------------------------------------------------------
module dense_sigmoid_network_inference_core
    import dsn_pkg::*;
#(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_LAYERS = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              opcode,
    input  logic [1:0]              layer_sel,
    input  logic [4:0]              row_idx,
    input  logic [4:0]              col_idx,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    is_last,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [4:0]              out_index,
    output logic [ACT_W-1:0]        out_value,
    output logic                    out_last,
    input  logic                    cfg_wr_en,
    input  logic [CFG_A_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    localparam int WDEPTH = (MAX_LAYERS - 1) * MAX_WIDTH;
    localparam int WAW    = WDEPTH > 1 ? $clog2(WDEPTH) : 1;
    localparam int BDEPTH = MAX_LAYERS - 1;
    localparam int BAW    = BDEPTH > 1 ? $clog2(BDEPTH) : 1;
    localparam int AAW    = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
    localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int HI_L   = MAX_LAYERS < 4 ? MAX_LAYERS : 4;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FEED  = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [1:0]              layer_reg;
    logic [1:0]              layer_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic [CNT_W-1:0]        nin_reg;
    logic [CNT_W-1:0]        nin_next;
    logic [CNT_W-1:0]        nout_reg;
    logic [CNT_W-1:0]        nout_next;
    logic [2:0]              lcount_reg;
    logic [CFG_W-1:0]        width_reg [4];
    logic [2:0]              nl_eff;

    logic signed [VAL_W-1:0] ping [MAX_WIDTH];
    logic signed [VAL_W-1:0] pong [MAX_WIDTH];
    logic signed [VAL_W-1:0] ping_q;
    logic signed [VAL_W-1:0] pong_q;
    logic                    ping_we;
    logic                    pong_we;
    logic [AAW-1:0]          ping_waddr;
    logic signed [VAL_W-1:0] ping_wdata;
    logic signed [VAL_W-1:0] dst_wdata;

    logic                    rd_v_reg;
    logic                    rd_lst_reg;
    logic [IDX_W-1:0]        rd_k_reg;
    logic                    rd_pong_reg;
    logic                    feed;

    logic                    out_valid_reg;
    logic [4:0]              out_index_reg;
    logic [ACT_W-1:0]        out_value_reg;
    logic                    out_last_reg;
    logic                    out_load;

    logic                    in_xfer;
    logic                    w_ok;
    logic                    b_ok;
    logic                    i_ok;
    logic                    start;
    logic                    final_layer;
    logic                    drain_step;
    logic                    cnt_end;
    logic [WAW-1:0]          w_addr;
    logic [BAW-1:0]          b_addr;
    logic [BAW-1:0]          lay_rd;
    sh_ctl_t                 ctl;

    tok_t                    tok   [MAX_WIDTH+1];
    logic [ACT_W-1:0]        shv   [MAX_WIDTH+1];
    logic                    done  [MAX_WIDTH];
    cell_wr_t                cwr   [MAX_WIDTH];

    function automatic logic [CNT_W-1:0] eff_w(input logic [CFG_W-1:0] w);
        if (w == '0)
            return CNT_W'(1);
        else if (int'(w) > MAX_WIDTH)
            return CNT_W'(MAX_WIDTH);
        else
            return CNT_W'(w);
    endfunction

    always_comb
    begin
        if (lcount_reg < 3'd2)
            nl_eff = 3'd2;
        else if (int'(lcount_reg) > HI_L)
            nl_eff = 3'(HI_L);
        else
            nl_eff = lcount_reg;
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcount_reg <= 3'd3;
            for (int i = 0; i < 4; i++)
                width_reg[i] <= CFG_W'(32);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_LAYERS: lcount_reg   <= cfg_data[2:0];
                REG_WIN:    width_reg[0] <= cfg_data;
                REG_W1:     width_reg[1] <= cfg_data;
                REG_W2:     width_reg[2] <= cfg_data;
                REG_W3:     width_reg[3] <= cfg_data;
                default:    ;
            endcase
        end
    end

    // load decode
    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid & in_ready;
    assign w_ok     = in_xfer && opcode == OP_WEIGHT && int'(layer_sel) < MAX_LAYERS - 1
                      && int'(row_idx) < MAX_WIDTH && int'(col_idx) < MAX_WIDTH;
    assign b_ok     = in_xfer && opcode == OP_BIAS && int'(layer_sel) < MAX_LAYERS - 1
                      && int'(row_idx) < MAX_WIDTH;
    assign i_ok     = in_xfer && opcode == OP_INPUT && int'(row_idx) < MAX_WIDTH;
    assign start    = i_ok & is_last;
    assign w_addr   = WAW'(layer_sel) * WAW'(MAX_WIDTH) + WAW'(row_idx);
    assign b_addr   = BAW'(layer_sel);
    assign lay_rd   = BAW'(layer_reg);

    assign final_layer = ({1'b0, layer_reg} == nl_eff - 3'd2);
    assign cnt_end     = (cnt_reg == nout_reg - CNT_W'(1));
    assign out_load    = (state_reg == S_DRAIN) && final_layer
                         && (!out_valid_reg || out_ready);
    assign drain_step  = (state_reg == S_DRAIN) && (!final_layer || out_load);
    assign feed        = (state_reg == S_FEED);

    always_comb
    begin
        ctl.ld = (state_reg == S_LOAD);
        ctl.sh = drain_step;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        layer_next = layer_reg;
        cnt_next   = cnt_reg;
        nin_next   = nin_reg;
        nout_next  = nout_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_FEED;
                    layer_next = 2'd0;
                    cnt_next   = '0;
                    nin_next   = eff_w(width_reg[0]);
                    nout_next  = eff_w(width_reg[1]);
                end
            end
            S_FEED:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == nin_reg - CNT_W'(1))
                    state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (done[MAX_WIDTH-1])
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cnt_next   = '0;
                state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (drain_step)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (cnt_end)
                    begin
                        cnt_next = '0;
                        if (final_layer)
                            state_next = S_IDLE;
                        else
                        begin
                            state_next = S_FEED;
                            layer_next = layer_reg + 2'd1;
                            nin_next   = nout_reg;
                            nout_next  = eff_w(width_reg[layer_reg + 2'd2]);
                        end
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            layer_reg <= '0;
            cnt_reg   <= '0;
            nin_reg   <= '0;
            nout_reg  <= '0;
            rd_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            layer_reg <= layer_next;
            cnt_reg   <= cnt_next;
            nin_reg   <= nin_next;
            nout_reg  <= nout_next;
            rd_v_reg  <= feed;
        end
    end

    // activation buffers, every layer writes its outputs back
    assign dst_wdata  = {{(VAL_W-ACT_W){1'b0}}, shv[0]};
    assign ping_we    = i_ok || (drain_step && layer_reg[0]);
    assign pong_we    = drain_step && !layer_reg[0];
    assign ping_waddr = i_ok ? AAW'(row_idx) : cnt_reg[AAW-1:0];
    assign ping_wdata = i_ok ? value : dst_wdata;

    always_ff @(posedge clk)
    begin
        if (ping_we)
            ping[ping_waddr] <= ping_wdata;
        ping_q <= ping[cnt_reg[AAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (pong_we)
            pong[cnt_reg[AAW-1:0]] <= dst_wdata;
        pong_q <= pong[cnt_reg[AAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        rd_k_reg    <= IDX_W'(cnt_reg);
        rd_lst_reg  <= (cnt_reg == nin_reg - CNT_W'(1));
        rd_pong_reg <= layer_reg[0];
    end

    always_comb
    begin
        tok[0].vld = rd_v_reg;
        tok[0].lst = rd_lst_reg;
        tok[0].k   = rd_k_reg;
        tok[0].act = rd_pong_reg ? pong_q : ping_q;
    end

    assign shv[MAX_WIDTH] = '0;

    // cell row
    for (genvar j = 0; j < MAX_WIDTH; j++)
    begin : g_cell
        always_comb
        begin
            cwr[j].w_en = w_ok && (int'(col_idx) == j);
            cwr[j].b_en = b_ok && (int'(row_idx) == j);
        end

        dsn_cell #(
            .MAX_WIDTH  (MAX_WIDTH),
            .MAX_LAYERS (MAX_LAYERS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (cwr[j]),
            .w_addr  (w_addr),
            .b_addr  (b_addr),
            .lay     (lay_rd),
            .wr_data (value),
            .tok_in  (tok[j]),
            .tok_out (tok[j+1]),
            .ctl     (ctl),
            .sh_in   (shv[j+1]),
            .sh_out  (shv[j]),
            .done    (done[j])
        );
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_index_reg <= 5'(cnt_reg);
            out_value_reg <= shv[0];
            out_last_reg  <= cnt_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== bench/dsn_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsn_checker
// Watches the load, input and result channels of the dense network core,
// keeps its own copy of the weight, bias and activation stores, runs each
// forward pass when the final input element transfers, and compares every
// result transfer with the oldest predicted index, activation and last flag.
// ----------------------------------------------------------------------------
module dsn_checker
    import dsn_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [1:0]              opcode,
    input  logic [1:0]              layer_sel,
    input  logic [4:0]              row_idx,
    input  logic [4:0]              col_idx,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    is_last,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [4:0]              out_index,
    input  logic [ACT_W-1:0]        out_value,
    input  logic                    out_last,
    input  logic                    cfg_wr_en,
    input  logic [CFG_A_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    output int                      fails,
    output int                      pending
);

    typedef struct packed {
        logic [4:0]       idx;
        logic [ACT_W-1:0] act;
        logic             lst;
    } neuron_out_t;

    logic signed [VAL_W-1:0] weights [3][32][32];
    logic signed [VAL_W-1:0] biases [3][32];
    logic signed [VAL_W-1:0] ping [32];
    logic signed [VAL_W-1:0] pong [32];
    logic [ACT_W-1:0]        curve [TAB_N];
    logic [2:0]              layers_reg;
    logic [5:0]              width_reg [4];
    neuron_out_t             outputs_due [$];

    initial
    begin
        logic [63:0] p;
        logic [63:0] den;
        p = 64'd1 << 32;
        for (int k = 0; k <= 128; k++)
        begin
            den = (64'd1 << 32) + p;
            if (k < 128)
                curve[128 + k] = ACT_W'(((64'd1 << 44) + den / 2) / den);
            if (k > 0)
                curve[128 - k] = ACT_W'((64'd4096 * p + den / 2) / den);
            p = (p * 64'd4034748380) >> 32;
        end
    end

    function automatic int layers_used();
        int n;
        n = int'(layers_reg);
        if (n < 2) n = 2;
        if (n > 4) n = 4;
        return n;
    endfunction

    function automatic int width_used(int i);
        int w;
        w = int'(width_reg[i]);
        if (w < 1) w = 1;
        if (w > 32) w = 32;
        return w;
    endfunction

    function automatic logic [ACT_W-1:0] squash(logic signed [ACC_W-1:0] a);
        logic [ACC_W-1:0] t;
        t = a + 40'sd134217728;
        if (a < -40'sd134217728)
            return '0;
        if (a >= 40'sd134217728)
            return ACT_W'(4096);
        return curve[t[27:20]];
    endfunction

    task automatic forward_pass();
        int                      n_in;
        int                      n_out;
        bit                      from_ping;
        logic signed [ACC_W-1:0] acc;
        logic signed [31:0]      prod;
        logic signed [VAL_W-1:0] x;
        logic [ACT_W-1:0]        res [32];
        neuron_out_t             r;
        from_ping = 1;
        n_out = 1;
        for (int l = 0; l + 1 < layers_used(); l++)
        begin
            n_in  = width_used(l);
            n_out = width_used(l + 1);
            for (int j = 0; j < n_out; j++)
            begin
                acc = ACC_W'(biases[l][j]);
                acc = acc <<< FRAC;
                for (int k = 0; k < n_in; k++)
                begin
                    x    = from_ping ? ping[k] : pong[k];
                    prod = 32'(weights[l][k][j]) * 32'(x);
                    acc  = acc + ACC_W'(prod);
                end
                res[j] = squash(acc);
            end
            for (int j = 0; j < n_out; j++)
            begin
                if (from_ping)
                    pong[j] = VAL_W'(res[j]);
                else
                    ping[j] = VAL_W'(res[j]);
            end
            from_ping = !from_ping;
        end
        for (int j = 0; j < n_out; j++)
        begin
            r.idx = 5'(j);
            r.act = from_ping ? ACT_W'(ping[j]) : ACT_W'(pong[j]);
            r.lst = (j + 1 == n_out);
            outputs_due.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        neuron_out_t e;
        if (!rst_n)
        begin
            layers_reg = 3'd3;
            for (int i = 0; i < 4; i++) width_reg[i] = 6'd32;
            fails   = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_LAYERS)
                    layers_reg = cfg_data[2:0];
                else if (cfg_index >= REG_WIN && cfg_index <= REG_W3)
                    width_reg[cfg_index - REG_WIN] = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                case (opcode)
                    OP_WEIGHT: if (layer_sel < 3) weights[layer_sel][row_idx][col_idx] = value;
                    OP_BIAS:   if (layer_sel < 3) biases[layer_sel][row_idx] = value;
                    OP_INPUT:
                    begin
                        ping[row_idx] = value;
                        if (is_last) forward_pass();
                    end
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (outputs_due.size() == 0)
                begin
                    $display("%0t: unexpected result transfer index %0d value %0d last %0b",
                             $time, out_index, out_value, out_last);
                    fails++;
                end
                else
                begin
                    e = outputs_due.pop_front();
                    if (out_index !== e.idx)
                    begin
                        $display("%0t: out_index expected %0d actual %0d", $time, e.idx, out_index);
                        fails++;
                    end
                    if (out_value !== e.act)
                    begin
                        $display("%0t: out_value expected %0d actual %0d", $time, e.act, out_value);
                        fails++;
                    end
                    if (out_last !== e.lst)
                    begin
                        $display("%0t: out_last expected %0b actual %0b", $time, e.lst, out_last);
                        fails++;
                    end
                end
            end
            pending = outputs_due.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the dense network core: loads weights and biases, streams
// input elements that start forward passes, and steps through several layer
// counts and widths, with random gaps on both channels and a long result
// stall. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import dsn_pkg::*;

    localparam int LIMIT = 1000000;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [1:0]              opcode;
    logic [1:0]              layer_sel;
    logic [4:0]              row_idx;
    logic [4:0]              col_idx;
    logic signed [VAL_W-1:0] value;
    logic                    is_last;
    logic                    out_valid;
    logic                    out_ready;
    logic [4:0]              out_index;
    logic [ACT_W-1:0]        out_value;
    logic                    out_last;
    logic                    cfg_wr_en;
    logic [CFG_A_W-1:0]      cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    int                      fails;
    int                      pending;
    int                      cycles;
    bit                      steady;
    bit                      hold_req;

    bit w_known [3][32][32];
    bit b_known [3][32];
    bit x_known [32];
    int cfg_shadow [5];

    dense_sigmoid_network_inference_core dut (.*);

    dsn_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("dense_sigmoid_network_inference_core test failed");
            $finish;
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            out_ready <= steady || $urandom_range(99) >= 36;
        end
    end

    function automatic int n_layers();
        int n;
        n = cfg_shadow[0];
        if (n < 2) n = 2;
        if (n > 4) n = 4;
        return n;
    endfunction

    function automatic int n_width(int i);
        int w;
        w = cfg_shadow[i + 1];
        if (w < 1) w = 1;
        if (w > 32) w = 32;
        return w;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        int s;
        s = $urandom_range(99);
        if (s < 6) return 16'sh8000;
        if (s < 12) return 16'sh7fff;
        if (s < 15) return '0;
        if (s < 30) return VAL_W'($urandom);
        return VAL_W'($urandom_range(0, 4095) - 2048);
    endfunction

    task automatic send(logic [1:0] op, logic [1:0] lay, logic [4:0] r, logic [4:0] c,
                        logic signed [VAL_W-1:0] v, logic lst);
        while (!steady && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        layer_sel <= lay;
        row_idx   <= r;
        col_idx   <= c;
        value     <= v;
        is_last   <= lst;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if (op == OP_WEIGHT && lay < 3) w_known[lay][r][c] = 1;
        if (op == OP_BIAS && lay < 3) b_known[lay][r] = 1;
        if (op == OP_INPUT)
        begin
            x_known[r] = 1;
            if (lst && n_layers() == 4)
                for (int j = 0; j < n_width(2); j++) x_known[j] = 1;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic set_config(int lc, int a, int b, int c, int d);
        drain();
        cfg_shadow = '{lc, a, b, c, d};
        cfg_wr_en <= 1'b1;
        for (int i = 0; i < 5; i++)
        begin
            cfg_index <= CFG_A_W'(REG_LAYERS + i);
            cfg_data  <= CFG_W'(cfg_shadow[i]);
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_network(int rewrite_pct);
        for (int l = 0; l + 1 < n_layers(); l++)
        begin
            for (int j = 0; j < n_width(l + 1); j++)
            begin
                for (int k = 0; k < n_width(l); k++)
                    if (!w_known[l][k][j] || $urandom_range(99) < rewrite_pct)
                        send(OP_WEIGHT, 2'(l), 5'(k), 5'(j), pick_value(),
                             1'($urandom_range(1)));
                if (!b_known[l][j] || $urandom_range(99) < rewrite_pct)
                    send(OP_BIAS, 2'(l), 5'(j), 5'($urandom), pick_value(),
                         1'($urandom_range(1)));
            end
        end
    endtask

    task automatic run_pass();
        for (int r = 0; r < n_width(0); r++)
            if (!x_known[r] || $urandom_range(1))
                send(OP_INPUT, 2'($urandom), 5'(r), 5'($urandom), pick_value(), 1'b0);
        send(OP_INPUT, 2'($urandom), 5'($urandom), 5'($urandom), pick_value(), 1'b1);
    endtask

    task automatic send_noise();
        logic [1:0] op;
        logic [1:0] lay;
        logic [4:0] r;
        logic       lst;
        op  = 2'($urandom);
        lay = 2'($urandom);
        r   = 5'($urandom);
        lst = 1'($urandom_range(1));
        // never start a pass that would read an element not yet sent
        if (op == OP_INPUT && lst)
            for (int k = 0; k < n_width(0); k++)
                if (!x_known[k] && k != r) lst = 1'b0;
        send(op, lay, r, 5'($urandom), VAL_W'($urandom), lst);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        opcode    = '0;
        layer_sel = '0;
        row_idx   = '0;
        col_idx   = '0;
        value     = '0;
        is_last   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        steady    = 0;
        hold_req  = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // smallest network, extreme values, ignored items
        set_config(2, 1, 1, 1, 1);
        send(OP_WEIGHT, 2'd0, 5'd0, 5'd0, 16'sh7fff, 1'b1);
        send(OP_BIAS, 2'd0, 5'd0, 5'd0, 16'sh7fff, 1'b1);
        send(OP_INPUT, 2'd0, 5'd0, 5'd0, 16'sh7fff, 1'b1);
        send(OP_WEIGHT, 2'd0, 5'd0, 5'd0, 16'sh8000, 1'b0);
        send(OP_BIAS, 2'd0, 5'd0, 5'd0, 16'sh8000, 1'b0);
        send(OP_INPUT, 2'd3, 5'd0, 5'd31, 16'sh7fff, 1'b1);
        send(OP_WEIGHT, 2'd0, 5'd0, 5'd0, 16'sh0000, 1'b0);
        send(OP_BIAS, 2'd0, 5'd0, 5'd0, 16'sh0000, 1'b0);
        send(OP_INPUT, 2'd0, 5'd0, 5'd0, 16'sh1000, 1'b1);
        send(2'd3, 2'd0, 5'd0, 5'd0, 16'sh1234, 1'b1);
        send(OP_WEIGHT, 2'd3, 5'd31, 5'd31, 16'sh4321, 1'b1);
        send(OP_BIAS, 2'd3, 5'd31, 5'd0, 16'sh4321, 1'b0);
        send(OP_BIAS, 2'd0, 5'd0, 5'd0, 16'sh0800, 1'b0);
        send(OP_INPUT, 2'd1, 5'd31, 5'd0, 16'shffff, 1'b0);
        send(OP_INPUT, 2'd0, 5'd0, 5'd0, 16'shf000, 1'b1);

        // widest output layer, long result stall while items keep coming
        set_config(2, 1, 32, 1, 1);
        load_network(0);
        run_pass();
        hold_req = 1;
        repeat (3) run_pass();

        // four layers with mixed widths
        set_config(4, 2, 1, 2, 3);
        load_network(0);
        repeat (2) run_pass();

        // register values out of range saturate
        set_config(0, 0, 40, 0, 0);
        load_network(0);
        run_pass();
        set_config(7, 1, 0, 2, 3);
        load_network(0);
        run_pass();

        for (int round = 0; round < 8; round++)
        begin
            steady = (round >= 2 && round < 5);
            set_config($urandom_range(2, 4), $urandom_range(1, 3), $urandom_range(1, 3),
                       $urandom_range(1, 3), $urandom_range(1, 3));
            load_network(10);
            repeat ($urandom_range(2, 4))
            begin
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(1, 4)) send_noise();
                if ($urandom_range(4) == 0)
                    drain();
                run_pass();
            end
        end
        steady = 0;

        drain();
        repeat (200) @(negedge clk);
        if (fails == 0)
            $display("dense_sigmoid_network_inference_core test passed");
        else
            $display("dense_sigmoid_network_inference_core test failed");
        $finish;
    end

endmodule
